/* design/kcsg_pkg.sv */
// Shared types, constants and helper functions for the Koch curve segment generator.
package kcsg_pkg;

  localparam int COORD_W = 24;
  localparam int MUL_W   = 28;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ACC_W   = 48;
  localparam int WIDE_W  = 36;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;
  typedef logic signed [MUL_W-1:0]   mul_op_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // Position of a point inside the five-point record of one stack level.
  typedef logic [2:0] slot_t;
  localparam slot_t SLOT_A  = 3'd0;
  localparam slot_t SLOT_P1 = 3'd1;
  localparam slot_t SLOT_P2 = 3'd2;
  localparam slot_t SLOT_P3 = 3'd3;
  localparam slot_t SLOT_B  = 3'd4;
  localparam int    POINTS_PER_LEVEL = 5;

  typedef struct packed {
    logic   en;
    slot_t  slot;
    point_t pt;
  } mem_wr_t;

  // Division by three: floor(m / 3) = (m * RECIP3) >> THIRD_SHIFT for 0 <= m < 2^27.
  localparam int      THIRD_SHIFT  = 28;
  localparam mul_op_t RECIP3       = 28'sd89478486;
  // Adding 3 * 2^25 keeps the dividend positive; the +1 turns floor into round-to-nearest.
  localparam mul_op_t THIRD_BIAS   = 28'sd100663297;
  localparam logic signed [26:0] THIRD_OFFSET = 27'sd33554432;

  // Rotation by +60 degrees, factors in Q1.16. cos60 is exactly 2^15.
  localparam mul_op_t SIN60_Q16    = 28'sd56756;
  localparam int      COS60_SHIFT  = 15;
  localparam int      ROT_SHIFT    = 16;
  localparam acc_t    ROUND_HALF   = 48'sd32768;

  localparam coord_t COORD_MAX = 24'sh7FFFFF;
  localparam coord_t COORD_MIN = 24'sh800000;

  localparam logic [1:0] LAST_CHILD  = 2'd3;
  localparam logic [1:0] DEPTH_RESET = 2'd3;
  localparam logic       CFG_IDX_DEPTH = 1'b0;

  function automatic coord_t sat_coord(input wide_t v);
    coord_t r;
    if (v > wide_t'(COORD_MAX)) begin
      r = COORD_MAX;
    end else if (v < wide_t'(COORD_MIN)) begin
      r = COORD_MIN;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

/* design/kcsg_mul.sv */
// Shared signed multiplier with a registered product.
module kcsg_mul (
  input  logic             clk,
  input  kcsg_pkg::mul_op_t op_a,
  input  kcsg_pkg::mul_op_t op_b,
  output kcsg_pkg::prod_t   prod_r
);
  import kcsg_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

/* design/kcsg_point_mem.sv */
// Stack point memory: one write port and two registered read ports.
module kcsg_point_mem #(
  parameter int DEPTH = 15,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  kcsg_pkg::point_t wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output kcsg_pkg::point_t rdata_a_r,
  output kcsg_pkg::point_t rdata_b_r
);
  import kcsg_pkg::*;

  point_t mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem_r[raddr_a];
      rdata_b_r <= mem_r[raddr_b];
    end
  end

endmodule

/* design/kcsg_subdiv.sv */
// Subdivision sequencer: computes the five points of one level on the shared multiplier.
module kcsg_subdiv (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  kcsg_pkg::point_t  seg_a,
  input  kcsg_pkg::point_t  seg_b,
  output logic              done,
  output kcsg_pkg::mem_wr_t wr
);
  import kcsg_pkg::*;

  typedef enum logic [3:0] {
    SD_THIRD_DX,
    SD_THIRD_DY,
    SD_THIRD_2DX,
    SD_THIRD_2DY,
    SD_ROT_UX,
    SD_ROT_UY,
    SD_SUM_X,
    SD_P2X,
    SD_WRITE_P2
  } step_t;

  logic    active_r, active_nxt;
  step_t   step_r, step_nxt;
  coord_t  p1x_r, p1y_r, p3x_r, p3y_r, p2x_r, p2y_r;
  acc_t    tmpx_r, tmpy_r;
  mul_op_t op_a, op_b;
  prod_t   prod_r;

  logic signed [24:0] dx, dy, ux, uy;
  logic signed [25:0] dx2, dy2;
  logic signed [26:0] quot;
  coord_t             third_base;
  coord_t             third_pt;

  function automatic mul_op_t third_arg(input logic signed [25:0] n);
    return mul_op_t'(n) + THIRD_BIAS;
  endfunction

  assign dx  = 25'(seg_b.x) - 25'(seg_a.x);
  assign dy  = 25'(seg_b.y) - 25'(seg_a.y);
  assign dx2 = $signed({dx, 1'b0});
  assign dy2 = $signed({dy, 1'b0});
  assign ux  = 25'(p3x_r) - 25'(p1x_r);
  assign uy  = 25'(p3y_r) - 25'(p1y_r);

  // Quotient of the product issued in the previous step, with the bias removed.
  assign quot       = $signed({1'b0, prod_r[THIRD_SHIFT+25:THIRD_SHIFT]}) - THIRD_OFFSET;
  assign third_base = (step_r == SD_THIRD_DY || step_r == SD_THIRD_2DY) ? seg_a.x : seg_a.y;
  assign third_pt   = sat_coord(wide_t'(third_base) + wide_t'(quot));

  kcsg_mul u_mul (
    .clk   (clk),
    .op_a  (op_a),
    .op_b  (op_b),
    .prod_r(prod_r)
  );

  always_comb begin
    op_a = '0;
    op_b = '0;
    wr   = '0;
    done = 1'b0;
    step_nxt   = step_r;
    active_nxt = active_r;
    if (start) begin
      active_nxt = 1'b1;
      step_nxt   = SD_THIRD_DX;
    end else if (active_r) begin
      case (step_r)
        SD_THIRD_DX: begin
          op_a = third_arg(26'(dx));
          op_b = RECIP3;
          wr   = '{en: 1'b1, slot: SLOT_A, pt: seg_a};
          step_nxt = SD_THIRD_DY;
        end
        SD_THIRD_DY: begin
          op_a = third_arg(26'(dy));
          op_b = RECIP3;
          wr   = '{en: 1'b1, slot: SLOT_B, pt: seg_b};
          step_nxt = SD_THIRD_2DX;
        end
        SD_THIRD_2DX: begin
          op_a = third_arg(dx2);
          op_b = RECIP3;
          step_nxt = SD_THIRD_2DY;
        end
        SD_THIRD_2DY: begin
          op_a = third_arg(dy2);
          op_b = RECIP3;
          wr   = '{en: 1'b1, slot: SLOT_P1, pt: '{x: p1x_r, y: p1y_r}};
          step_nxt = SD_ROT_UX;
        end
        SD_ROT_UX: begin
          op_a = mul_op_t'(ux);
          op_b = SIN60_Q16;
          step_nxt = SD_ROT_UY;
        end
        SD_ROT_UY: begin
          op_a = mul_op_t'(uy);
          op_b = SIN60_Q16;
          wr   = '{en: 1'b1, slot: SLOT_P3, pt: '{x: p3x_r, y: p3y_r}};
          step_nxt = SD_SUM_X;
        end
        SD_SUM_X: begin
          step_nxt = SD_P2X;
        end
        SD_P2X: begin
          step_nxt = SD_WRITE_P2;
        end
        SD_WRITE_P2: begin
          wr   = '{en: 1'b1, slot: SLOT_P2, pt: '{x: p2x_r, y: p2y_r}};
          done = 1'b1;
          active_nxt = 1'b0;
        end
        default: begin
          active_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      step_r   <= SD_THIRD_DX;
    end else begin
      active_r <= active_nxt;
      step_r   <= step_nxt;
      if (active_r) begin
        case (step_r)
          SD_THIRD_DY:  p1x_r <= third_pt;
          SD_THIRD_2DX: p1y_r <= third_pt;
          SD_THIRD_2DY: p3x_r <= third_pt;
          SD_ROT_UX:    p3y_r <= third_pt;
          SD_ROT_UY: begin
            tmpy_r <= acc_t'(prod_r) + (acc_t'(uy) <<< COS60_SHIFT) + ROUND_HALF;
          end
          SD_SUM_X: begin
            tmpx_r <= (acc_t'(ux) <<< COS60_SHIFT) + ROUND_HALF - acc_t'(prod_r);
            p2y_r  <= sat_coord(wide_t'(p1y_r) + wide_t'(tmpy_r >>> ROT_SHIFT));
          end
          SD_P2X: begin
            p2x_r  <= sat_coord(wide_t'(p1x_r) + wide_t'(tmpx_r >>> ROT_SHIFT));
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

/* design/koch_curve_segment_generator.sv */
// Top level of the Koch curve segment generator: depth-first walk, stack and ports.
//
// Channel | Direction | Transfer when          | Payload
// in_     | slave     | in_tvalid & in_tready  | one segment (start, end), Q16.8
// out_    | master    | out_tvalid & out_tready| one sub-segment, tlast on the final one
// cfg_    | APB write | psel & penable & pwrite| curve_depth at byte address 0
//
// One input segment occupies the block until its last sub-segment is handed to the
// output register. Each subdivision runs on the shared multiplier, each stack read
// passes through the read and fetch states and each sub-segment through the emit
// state. Depth d needs S = (4^d-1)/3 subdivisions for 4^d sub-segments; depth 0
// goes straight to emit. A stalled output holds the walk in place.
// Reset is synchronous and active low; it clears the walk and sets curve_depth to 3.
module koch_curve_segment_generator #(
  parameter int MAX_DEPTH = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input segment stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,    // start_x, start_y, end_x, end_y (24 bits each)
  // Output sub-segment stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,   // seg_from_x, seg_from_y, seg_to_x, seg_to_y
  output logic        out_tlast,   // last_segment
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import kcsg_pkg::*;

  localparam int MEM_DEPTH = POINTS_PER_LEVEL * MAX_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int LW        = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUBDIV,
    ST_READ,
    ST_FETCH,
    ST_EMIT
  } state_t;

  state_t         state_r, state_nxt;
  logic [LW-1:0]  lvl_r, lvl_nxt;
  logic [1:0]     child_r [MAX_DEPTH];
  logic [1:0]     child_nxt [MAX_DEPTH];
  logic [1:0]     depth_r, depth_nxt;
  logic [1:0]     cfg_depth_r;
  point_t         seg_a_r, seg_a_nxt, seg_b_r, seg_b_nxt;
  point_t         out_from_r, out_from_nxt, out_to_r, out_to_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_last_r, out_last_nxt;

  logic [1:0]     eff_depth;
  logic           sub_start, sub_done;
  mem_wr_t        sub_wr;
  logic           rd_en;
  logic [AW-1:0]  lvl_base, waddr, raddr_a, raddr_b;
  point_t         rdata_a, rdata_b;
  logic           pop_found;
  logic [LW-1:0]  pop_lvl;
  logic           emit_last;
  logic           out_free;
  logic           cfg_wr;

  // Configuration register. Writes are assumed to arrive only while the block is idle.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == CFG_IDX_DEPTH);
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_DEPTH) ? {30'd0, cfg_depth_r} : 32'd0;
  assign eff_depth  = (cfg_depth_r > 2'(MAX_DEPTH)) ? 2'(MAX_DEPTH) : cfg_depth_r;

  // Each stack level owns five consecutive memory entries: A, P1, P2, P3, B.
  assign lvl_base = AW'({lvl_r, 2'b00}) + AW'(lvl_r);
  assign waddr    = lvl_base + AW'(sub_wr.slot);
  assign raddr_a  = lvl_base + AW'(child_r[lvl_r]);
  assign raddr_b  = raddr_a + AW'(1);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_to_r.y, out_to_r.x, out_from_r.y, out_from_r.x};
  assign out_tlast  = out_last_r;
  assign out_free   = !out_valid_r || out_tready;

  kcsg_subdiv u_subdiv (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sub_start),
    .seg_a(seg_a_r),
    .seg_b(seg_b_r),
    .done (sub_done),
    .wr   (sub_wr)
  );

  kcsg_point_mem #(
    .DEPTH(MEM_DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk      (clk),
    .we       (sub_wr.en),
    .waddr    (waddr),
    .wdata    (sub_wr.pt),
    .re       (rd_en),
    .raddr_a  (raddr_a),
    .raddr_b  (raddr_b),
    .rdata_a_r(rdata_a),
    .rdata_b_r(rdata_b)
  );

  // After a leaf is emitted, the walk resumes at the deepest level at or above the
  // current one that still has a child left. If there is none, the segment is done.
  always_comb begin
    pop_found = 1'b0;
    pop_lvl   = '0;
    for (int l = 0; l < MAX_DEPTH; l++) begin
      if (LW'(l) <= lvl_r && child_r[l] != LAST_CHILD) begin
        pop_found = 1'b1;
        pop_lvl   = LW'(l);
      end
    end
    emit_last = (depth_r == 2'd0) || !pop_found;
  end

  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    child_nxt     = child_r;
    depth_nxt     = depth_r;
    seg_a_nxt     = seg_a_r;
    seg_b_nxt     = seg_b_r;
    out_from_nxt  = out_from_r;
    out_to_nxt    = out_to_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;
    sub_start     = 1'b0;
    rd_en         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          seg_a_nxt = '{x: in_tdata[23:0],  y: in_tdata[47:24]};
          seg_b_nxt = '{x: in_tdata[71:48], y: in_tdata[95:72]};
          depth_nxt = eff_depth;
          if (eff_depth == 2'd0) begin
            state_nxt = ST_EMIT;
          end else begin
            sub_start    = 1'b1;
            lvl_nxt      = '0;
            child_nxt[0] = 2'd0;
            state_nxt    = ST_SUBDIV;
          end
        end
      end
      ST_SUBDIV: begin
        if (sub_done) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = ST_FETCH;
      end
      ST_FETCH: begin
        seg_a_nxt = rdata_a;
        seg_b_nxt = rdata_b;
        if (3'(lvl_r) + 3'd1 < 3'(depth_r)) begin
          sub_start                   = 1'b1;
          lvl_nxt                     = lvl_r + LW'(1);
          child_nxt[lvl_r + LW'(1)]   = 2'd0;
          state_nxt                   = ST_SUBDIV;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_from_nxt  = seg_a_r;
          out_to_nxt    = seg_b_r;
          out_last_nxt  = emit_last;
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end else begin
            lvl_nxt            = pop_lvl;
            child_nxt[pop_lvl] = child_r[pop_lvl] + 2'd1;
            state_nxt          = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lvl_r       <= '0;
      depth_r     <= '0;
      cfg_depth_r <= DEPTH_RESET;
      out_valid_r <= 1'b0;
      for (int l = 0; l < MAX_DEPTH; l++) begin
        child_r[l] <= 2'd0;
      end
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= lvl_nxt;
      child_r     <= child_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
      seg_a_r     <= seg_a_nxt;
      seg_b_r     <= seg_b_nxt;
      out_from_r  <= out_from_nxt;
      out_to_r    <= out_to_nxt;
      out_last_r  <= out_last_nxt;
      if (cfg_wr) begin
        cfg_depth_r <= cfg_pwdata[1:0];
      end
    end
  end

  // Every subdivision that is started runs through all its steps and reports completion.
  a_subdiv_latency: assert property (@(posedge clk) disable iff (!rst_n)
    sub_start |-> ##9 sub_done)
    else $error("subdivision did not finish on schedule");

  // The subdivision unit only reports completion while the walk waits for it.
  a_done_in_subdiv: assert property (@(posedge clk) disable iff (!rst_n)
    sub_done |-> (state_r == ST_SUBDIV))
    else $error("subdivision finished outside the subdivide state");

  // Stack reads never address a level beyond the effective depth.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ || state_r == ST_FETCH) |-> (3'(lvl_r) < 3'(depth_r)))
    else $error("stack level outside the effective depth");

  // Handing over the final sub-segment returns the block to idle with out_tlast set.
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free && emit_last) |=> (state_r == ST_IDLE && out_tlast))
    else $error("walk continued after the final sub-segment");

endmodule

/* sim/kcsg_checker.sv */
// Checker for the Koch curve segment generator: predicts every sub-segment and compares it.
module kcsg_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,    // start_x, start_y, end_x, end_y (24 bits each)
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [95:0] out_tdata,   // seg_from_x, seg_from_y, seg_to_x, seg_to_y
  input  logic        out_tlast,   // last_segment
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int unsigned outstanding,
  output int unsigned fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import kcsg_pkg::*;

  localparam int     MAX_LEVELS = 3;
  localparam longint COS60      = 32768;
  localparam longint SIN60      = 56756;
  localparam longint Q16_HALF   = 32768;
  localparam longint Q16_ONE    = 65536;

  typedef struct packed {
    coord_t end_y;
    coord_t end_x;
    coord_t start_y;
    coord_t start_x;
  } endpoints_t;

  typedef struct packed {
    logic   last;
    coord_t to_y;
    coord_t to_x;
    coord_t from_y;
    coord_t from_x;
  } subseg_t;

  subseg_t    expected_subsegs[$];
  logic [1:0] curve_depth;
  // Five points (A, P1, peak, P3, B) per level of the walk.
  longint     walk_x[5*MAX_LEVELS];
  longint     walk_y[5*MAX_LEVELS];
  string      field_names[5] = '{"seg_from_x", "seg_from_y", "seg_to_x", "seg_to_y",
                                 "last_segment"};

  function automatic longint div_floor(longint num, longint den);
    longint q;
    q = num / den;
    if ((num % den != 0) && (num < 0)) q = q - 1;
    return q;
  endfunction

  function automatic coord_t clamp24(longint v);
    if (v > longint'(COORD_MAX)) return COORD_MAX;
    if (v < longint'(COORD_MIN)) return COORD_MIN;
    return coord_t'(v);
  endfunction

  // Thirds are rounded to nearest as floor((n+1)/3); the peak rounds half up.
  function automatic void split_segment(int base, longint ax, longint ay,
                                        longint bx, longint by);
    longint p1x, p1y, p3x, p3y, ux, uy;
    p1x = longint'(clamp24(ax + div_floor(bx - ax + 1, 3)));
    p1y = longint'(clamp24(ay + div_floor(by - ay + 1, 3)));
    p3x = longint'(clamp24(ax + div_floor(2 * (bx - ax) + 1, 3)));
    p3y = longint'(clamp24(ay + div_floor(2 * (by - ay) + 1, 3)));
    ux  = p3x - p1x;
    uy  = p3y - p1y;
    walk_x[base]     = ax;
    walk_y[base]     = ay;
    walk_x[base + 1] = p1x;
    walk_y[base + 1] = p1y;
    walk_x[base + 2] = longint'(clamp24(p1x + div_floor(COS60 * ux - SIN60 * uy + Q16_HALF,
                                                        Q16_ONE)));
    walk_y[base + 2] = longint'(clamp24(p1y + div_floor(SIN60 * ux + COS60 * uy + Q16_HALF,
                                                        Q16_ONE)));
    walk_x[base + 3] = p3x;
    walk_y[base + 3] = p3y;
    walk_x[base + 4] = bx;
    walk_y[base + 4] = by;
  endfunction

  function automatic void expect_subseg(longint fx, longint fy, longint tx, longint ty,
                                        logic is_last);
    expected_subsegs.push_back(subseg_t'{last: is_last, to_y: coord_t'(ty),
                                         to_x: coord_t'(tx), from_y: coord_t'(fy),
                                         from_x: coord_t'(fx)});
  endfunction

  // Depth-first walk over the 4^levels sub-segments of one input segment.
  function automatic void predict_subsegs(endpoints_t seg, int levels);
    longint ax, ay, bx, by;
    int     child[MAX_LEVELS];
    int     lvl;
    int     base;
    bit     descend;
    if (levels == 0) begin
      expect_subseg(longint'(seg.start_x), longint'(seg.start_y), longint'(seg.end_x),
                    longint'(seg.end_y), 1'b1);
      return;
    end
    ax = longint'(seg.start_x);
    ay = longint'(seg.start_y);
    bx = longint'(seg.end_x);
    by = longint'(seg.end_y);
    lvl = 0;
    descend = 1'b1;
    while (lvl >= 0) begin
      if (descend) begin
        split_segment(lvl * 5, ax, ay, bx, by);
        child[lvl] = 0;
      end
      base = lvl * 5 + child[lvl];
      ax = walk_x[base];
      ay = walk_y[base];
      bx = walk_x[base + 1];
      by = walk_y[base + 1];
      if (lvl + 1 < levels) begin
        lvl++;
        descend = 1'b1;
      end else begin
        expect_subseg(ax, ay, bx, by, 1'b0);
        descend = 1'b0;
        while (lvl >= 0 && child[lvl] == LAST_CHILD) lvl--;
        if (lvl >= 0) child[lvl]++;
      end
    end
    expected_subsegs[expected_subsegs.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    endpoints_t seg;
    subseg_t    got;
    subseg_t    want;
    longint     want_f[5];
    longint     got_f[5];
    if (!rst_n) begin
      curve_depth = DEPTH_RESET;
      fail_count  = 0;
      expected_subsegs.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == {CFG_IDX_DEPTH, 2'b00}) begin
        curve_depth = cfg_pwdata[1:0];
      end
      if (in_tvalid && in_tready) begin
        seg = in_tdata;
        predict_subsegs(seg, (curve_depth > MAX_LEVELS) ? MAX_LEVELS : int'(curve_depth));
      end
      if (out_tvalid && out_tready) begin
        got = {out_tlast, out_tdata};
        if (expected_subsegs.size() == 0) begin
          fail_count++;
          $display("%0t: sub-segment expected none, got (%0d,%0d)->(%0d,%0d) last=%0b",
                   $time, got.from_x, got.from_y, got.to_x, got.to_y, got.last);
        end else begin
          want = expected_subsegs.pop_front();
          want_f = '{longint'(want.from_x), longint'(want.from_y), longint'(want.to_x),
                     longint'(want.to_y), longint'(want.last)};
          got_f  = '{longint'(got.from_x), longint'(got.from_y), longint'(got.to_x),
                     longint'(got.to_y), longint'(got.last)};
          foreach (want_f[f]) begin
            if (want_f[f] !== got_f[f]) begin
              fail_count++;
              $display("%0t: %s expected %0d, got %0d", $time, field_names[f],
                       want_f[f], got_f[f]);
            end
          end
        end
      end
    end
    outstanding = expected_subsegs.size();
  end

endmodule

/* sim/tb_top.sv */
// Testbench top for the Koch curve segment generator: clock, reset, stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import kcsg_pkg::*;

  // Same layout as in_tdata: start_x sits in the lowest 24 bits.
  typedef struct packed {
    coord_t end_y;
    coord_t end_x;
    coord_t start_y;
    coord_t start_x;
  } endpoints_t;

  // Shapes of out_tready that the receiver switches between.
  typedef enum int {
    ALWAYS_READY,
    COIN_FLIP,
    MOSTLY_STALLED,
    PERIODIC,
    MOSTLY_READY
  } ready_mode_t;

  localparam int LONG_HOLD_CYCLES = 400;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int unsigned outstanding;
  int unsigned fail_count;
  logic        long_hold_req;

  // Directed segments. The first eight are the corner cases of the coordinate
  // range, which also get replayed with subdivision switched off. The rest are
  // degenerate or tiny segments where the rounding of thirds and of the peak
  // is easy to get wrong, including a peak that lands exactly on a half.
  endpoints_t directed_segs[15] = '{
    '{start_x: COORD_MIN, start_y: COORD_MIN, end_x: COORD_MAX, end_y: COORD_MAX},
    '{start_x: COORD_MAX, start_y: COORD_MAX, end_x: COORD_MIN, end_y: COORD_MIN},
    '{start_x: COORD_MIN, start_y: '0,        end_x: COORD_MAX, end_y: '0},
    '{start_x: COORD_MAX, start_y: '0,        end_x: COORD_MIN, end_y: '0},
    '{start_x: '0,        start_y: COORD_MIN, end_x: '0,        end_y: COORD_MAX},
    '{start_x: COORD_MAX, start_y: COORD_MIN, end_x: COORD_MIN, end_y: COORD_MAX},
    '{start_x: COORD_MAX, start_y: COORD_MAX, end_x: COORD_MAX, end_y: COORD_MAX},
    '{start_x: COORD_MIN, start_y: COORD_MIN, end_x: COORD_MIN, end_y: COORD_MIN},
    '{start_x: '0,        start_y: '0,        end_x: '0,        end_y: '0},
    '{start_x: '0,        start_y: '0,        end_x: 24'sd3,    end_y: '0},
    '{start_x: '0,        start_y: '0,        end_x: -24'sd3,   end_y: '0},
    '{start_x: '0,        start_y: '0,        end_x: '0,        end_y: 24'sd3},
    '{start_x: '0,        start_y: '0,        end_x: 24'sd768,  end_y: '0},
    '{start_x: -24'sd256, start_y: 24'sd512,  end_x: 24'sd2560, end_y: -24'sd1024},
    '{start_x: 24'sd1,    start_y: 24'sd2,    end_x: 24'sd2,    end_y: 24'sd1}
  };

  koch_curve_segment_generator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  kcsg_checker monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // A hard stop well beyond the slowest legal run: every item at full depth,
  // every sub-segment waiting out a stalled receiver, every gap at its longest.
  initial begin
    #8_000_000;
    $display("** koch_curve_segment_generator: FAILED **");
    $finish;
  end

  // Random coordinate. Style 0 spans the whole range, 1 stays near the origin
  // where the curve is drawn in practice, 2 hugs the rails so that the
  // computed points saturate, and 3 picks one of those per coordinate.
  function automatic coord_t random_coord(int style);
    if (style == 3) style = $urandom_range(0, 2);
    case (style)
      0: return coord_t'($urandom());
      1: return coord_t'(int'($urandom_range(0, 262144)) - 131072);
      default: begin
        if ($urandom_range(0, 1) == 1) return COORD_MAX - coord_t'($urandom_range(0, 4095));
        return COORD_MIN + coord_t'($urandom_range(0, 4095));
      end
    endcase
  endfunction

  // Offer one segment and hold it until the block takes the transfer. All
  // driving happens on the falling edge, and the task returns on one.
  task automatic offer_segment(input endpoints_t seg);
    in_tdata  = seg;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Every segment yields at least one sub-segment, so once nothing is owed
  // the block has gone idle; the settle wait that follows covers the output register.
  task automatic drain(input int settle);
    while (outstanding != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // APB write of curve_depth: a setup phase, then an access phase. The upper
  // bits of the data word carry noise, which the register must ignore.
  task automatic write_depth(input logic [1:0] depth);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {CFG_IDX_DEPTH, 2'b00};
    cfg_pwdata  = ($urandom() & ~32'd3) | 32'(depth);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // Receiver. It moves between ready patterns of random length. When the
  // stimulus asks for it, it holds out_tready low for a long stretch so the
  // block backs up and has to refuse input transfers.
  initial begin : receiver
    ready_mode_t mode;
    int          left;
    int          hold_left;
    bit          hold_taken;
    out_tready = 1'b0;
    mode       = ALWAYS_READY;
    left       = 0;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else begin
        if (left == 0) begin
          mode = ready_mode_t'($urandom_range(0, 4));
          left = $urandom_range(20, 300);
        end
        left--;
        case (mode)
          ALWAYS_READY:   out_tready = 1'b1;
          COIN_FLIP:      out_tready = 1'($urandom_range(0, 1));
          MOSTLY_STALLED: out_tready = ($urandom_range(0, 3) == 0);
          PERIODIC:       out_tready = ((left % 5) >= 2);
          default:        out_tready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Stimulus. Directed segments run first at the reset depth, and the first eight
  // again with subdivision off, then random phases walk through every depth. Phase 1
  // is the back-pressure phase: depth 0 makes transfers quick, the sender never
  // pauses, and the receiver is asked for its long hold.
  initial begin : stimulus
    int         phase_depth[9];
    int         phase_items[9];
    bit         phase_gaps[9];
    endpoints_t seg;
    int         style;
    int         burst_left;

    phase_depth   = '{0, 0, 1, 2, 3, 1, 0, 2, 3};
    phase_items   = '{80, 40, 80, 70, 40, 40, 30, 30, 20};
    phase_gaps    = '{1, 0, 1, 1, 1, 0, 1, 1, 0};
    long_hold_req = 1'b0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    // Reset leaves the full three levels of subdivision in place.
    foreach (directed_segs[i]) offer_segment(directed_segs[i]);
    in_tvalid = 1'b0;

    // With depth 0 every segment comes back unchanged, flagged as the last.
    drain(10);
    write_depth(2'd0);
    for (int i = 0; i < 8; i++) offer_segment(directed_segs[i]);
    in_tvalid = 1'b0;

    for (int p = 0; p < 9; p++) begin
      drain(10);
      write_depth(2'(phase_depth[p]));
      if (p == 1) long_hold_req = 1'b1;
      burst_left = $urandom_range(1, 12);
      for (int n = 0; n < phase_items[p]; n++) begin
        style         = $urandom_range(0, 3);
        seg.start_x   = random_coord(style);
        seg.start_y   = random_coord(style);
        seg.end_x     = random_coord(style);
        seg.end_y     = random_coord(style);
        // Now and then a zero-length or very short segment, where the thirds
        // collapse onto the endpoints.
        case ($urandom_range(0, 7))
          0: begin
            seg.end_x = seg.start_x;
            seg.end_y = seg.start_y;
          end
          1: begin
            seg.end_x = seg.start_x + coord_t'(int'($urandom_range(0, 8)) - 4);
            seg.end_y = seg.start_y + coord_t'(int'($urandom_range(0, 8)) - 4);
          end
          default: ;
        endcase
        offer_segment(seg);
        if (phase_gaps[p]) begin
          burst_left--;
          if (burst_left == 0) begin
            in_tvalid = 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
          end
        end
      end
      in_tvalid = 1'b0;
    end

    // Let the last sub-segments out, then watch a little longer for strays.
    drain(40);
    if (fail_count == 0) begin
      $display("** koch_curve_segment_generator: PASSED **");
    end else begin
      $display("** koch_curve_segment_generator: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
design/kcsg_pkg.sv
design/kcsg_mul.sv
design/kcsg_point_mem.sv
design/kcsg_subdiv.sv
design/koch_curve_segment_generator.sv
sim/kcsg_checker.sv
sim/tb_top.sv
